// File: rtl/core/mre_pkg.sv
// Package for the Modbus RTU master engine: state and command types,
// protocol codes, CRC-16 byte update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mre_pkg;

  localparam int STORE_DEPTH_DEF  = 256;
  localparam int DEVICE_COUNT_DEF = 15;
  localparam int STATUS_BASE_DEF  = 240;
  localparam int RX_DEPTH_DEF     = 256;

  localparam logic [2:0] MODE_RD_REQ   = 3'd0;
  localparam logic [2:0] MODE_WR_REQ   = 3'd1;
  localparam logic [2:0] MODE_RX_BYTE  = 3'd2;
  localparam logic [2:0] MODE_RX_END   = 3'd3;
  localparam logic [2:0] MODE_STORE_RD = 3'd4;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_STORE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CRC   = 3'd1;
  localparam logic [2:0] ST_WRONG     = 3'd2;
  localparam logic [2:0] ST_UNASKED   = 3'd3;
  localparam logic [2:0] ST_NO_ANSWER = 3'd4;
  localparam logic [2:0] ST_WR_ECHO   = 3'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REQ_CRC, S_REQ_TX, S_CHK_RD, S_CHK_USE, S_DEC,
    S_CP_RD, S_CP_USE, S_FIN, S_ST_TX
  } state_t;

  typedef struct packed {
    logic capture;
    logic req_arm;
    logic rx_push;
    logic clr_step;
    logic k_clr;
    logic k_inc;
    logic crc_req;
    logic emit_tx;
    logic rd_issue;
    logic chk_use;
    logic cp_start;
    logic cp_use;
    logic fin;
    logic emit_store;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
    logic req_crc_last;
    logic tx_last;
    logic len_ok;
    logic chk_last;
    logic cp_last;
    logic copy_go;
  } sts_t;

  // reflected CRC-16, one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mre_ctrl.sv
// Sequencer for the Modbus RTU master engine.
// Depends on mre_pkg; drives commands into mre_dp.
`timescale 1ns / 1ps
`default_nettype none
module mre_ctrl
  import mre_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_mode,
  output logic            in_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.k_clr   = 1'b1;
          case (in_mode)
            MODE_RD_REQ, MODE_WR_REQ: begin
              cmd.req_arm = 1'b1;
              state_nxt   = S_REQ_CRC;
            end
            MODE_RX_BYTE:  cmd.rx_push = 1'b1;
            MODE_RX_END:   state_nxt = sts.len_ok ? S_CHK_RD : S_FIN;
            MODE_STORE_RD: state_nxt = S_ST_TX;
            default: ;
          endcase
        end
      end
      S_REQ_CRC: begin
        cmd.crc_req = 1'b1;
        if (sts.req_crc_last) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_REQ_TX;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_REQ_TX: begin
        if (sts.out_free) begin
          cmd.emit_tx = 1'b1;
          cmd.k_inc   = 1'b1;
          if (sts.tx_last) state_nxt = S_IDLE;
        end
      end
      S_CHK_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CHK_USE;
      end
      S_CHK_USE: begin
        cmd.chk_use = 1'b1;
        cmd.k_inc   = 1'b1;
        state_nxt   = sts.chk_last ? S_DEC : S_CHK_RD;
      end
      S_DEC: begin
        if (sts.copy_go) begin
          cmd.cp_start = 1'b1;
          state_nxt    = S_CP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CP_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CP_USE;
      end
      S_CP_USE: begin
        cmd.cp_use = 1'b1;
        cmd.k_inc  = 1'b1;
        state_nxt  = sts.cp_last ? S_FIN : S_CP_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ST_TX: begin
        if (sts.out_free) begin
          cmd.emit_store = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/mre_dp.sv
// Datapath for the Modbus RTU master engine: request fields, CRC, reply
// buffer, register store, output register. Depends on mre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mre_dp
  import mre_pkg::*;
#(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int DEVICE_COUNT = DEVICE_COUNT_DEF,
  parameter int STATUS_BASE  = STATUS_BASE_DEF,
  parameter int RX_DEPTH     = RX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [2:0]         in_mode,
  input  wire logic [7:0]         in_device_addr,
  input  wire logic [15:0]        in_data_addr,
  input  wire logic [15:0]        in_count_or_value,
  input  wire logic [7:0]         in_store_start,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic [7:0]         in_store_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_tx_byte,
  output logic                    out_last,
  output logic [2:0]              out_status,
  output logic signed [15:0]      out_reg_value
);

  localparam int RX_IDX_W = $clog2(RX_DEPTH);
  localparam int RX_LEN_W = $clog2(RX_DEPTH + 1);
  localparam int ST_IDX_W = $clog2(STORE_DEPTH);
  localparam int SA_W     = $clog2(STATUS_BASE + DEVICE_COUNT + STORE_DEPTH + 512);

  logic [7:0]  rx_buf [RX_DEPTH];
  logic [15:0] st_mem [STORE_DEPTH];

  logic                awaiting_r;
  logic [7:0]          req_addr_r, req_func_r, req_count_low_r, req_start_r;
  logic [RX_LEN_W-1:0] rx_length_r, k_r;
  logic [15:0]         daddr_r, cv_r, crc_r;
  logic                mism_r, bad_r;
  logic [7:0]          rx_q_r, hi_r;
  logic [15:0]         st_rdata_r;
  logic [ST_IDX_W-1:0] clr_r;
  logic [SA_W-1:0]     word_idx_r;

  logic                out_valid_r, out_last_r;
  logic [1:0]          out_kind_r;
  logic [7:0]          out_tx_r;
  logic [2:0]          out_status_r;
  logic [15:0]         out_value_r;

  logic [RX_LEN_W-1:0] lenm1, lenm2, lenm3;
  logic [9:0]          expect_len;
  logic                len_ok, out_free;
  logic [7:0]          frame_byte;
  logic [2:0]          fin_status;
  logic [SA_W-1:0]     slot_addr, rd_addr, st_waddr;
  logic                slot_ok, st_we;
  logic [15:0]         st_wdata;

  assign lenm1 = rx_length_r - RX_LEN_W'(1);
  assign lenm2 = rx_length_r - RX_LEN_W'(2);
  assign lenm3 = rx_length_r - RX_LEN_W'(3);
  assign expect_len = (req_func_r == FUNC_READ) ? ({1'b0, req_count_low_r, 1'b0} + 10'd5)
                                                : 10'd8;
  assign len_ok   = awaiting_r && (10'(rx_length_r) == expect_len);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (k_r[2:0])
      3'd0:    frame_byte = req_addr_r;
      3'd1:    frame_byte = req_func_r;
      3'd2:    frame_byte = daddr_r[15:8];
      3'd3:    frame_byte = daddr_r[7:0];
      3'd4:    frame_byte = cv_r[15:8];
      3'd5:    frame_byte = cv_r[7:0];
      3'd6:    frame_byte = crc_r[7:0];
      default: frame_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    if (!len_ok)                 fin_status = (rx_length_r != '0) ? ST_UNASKED : ST_NO_ANSWER;
    else if (mism_r)             fin_status = ST_WRONG;
    else if (bad_r)              fin_status = ST_BAD_CRC;
    else if (req_func_r == FUNC_READ) fin_status = ST_OK;
    else                         fin_status = ST_WR_ECHO;
  end

  // status slot; device address 0 lands one below the base
  assign slot_addr = SA_W'(STATUS_BASE) + SA_W'(req_addr_r) - SA_W'(1);
  assign slot_ok   = (req_addr_r <= 8'(DEVICE_COUNT)) && (slot_addr < SA_W'(STORE_DEPTH));
  assign rd_addr   = SA_W'(in_store_index);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = SA_W'(clr_r);
    st_wdata = '0;
    if (cmd.clr_step) begin
      st_we = 1'b1;
    end else if (cmd.cp_use && !k_r[0]) begin
      st_we    = (word_idx_r < SA_W'(STORE_DEPTH));
      st_waddr = word_idx_r;
      st_wdata = {hi_r, rx_q_r};
    end else if (cmd.fin) begin
      st_we    = slot_ok;
      st_waddr = slot_addr;
      st_wdata = {13'd0, fin_status};
    end
  end

  always_comb begin
    sts.clr_done     = (clr_r == ST_IDX_W'(STORE_DEPTH - 1));
    sts.out_free     = out_free;
    sts.req_crc_last = (k_r == RX_LEN_W'(5));
    sts.tx_last      = (k_r[2:0] == 3'd7);
    sts.len_ok       = len_ok;
    sts.chk_last     = (k_r == lenm1);
    sts.cp_last      = (k_r == lenm3);
    sts.copy_go      = !mism_r && !bad_r && (req_func_r == FUNC_READ) &&
                       (req_count_low_r != 8'd0);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rx_push && (rx_length_r < RX_LEN_W'(RX_DEPTH)))
      rx_buf[rx_length_r[RX_IDX_W-1:0]] <= in_rx_byte;
    if (cmd.rd_issue)
      rx_q_r <= rx_buf[k_r[RX_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we)
      st_mem[st_waddr[ST_IDX_W-1:0]] <= st_wdata;
    if (cmd.capture && (in_mode == MODE_STORE_RD))
      st_rdata_r <= (rd_addr < SA_W'(STORE_DEPTH)) ? st_mem[rd_addr[ST_IDX_W-1:0]] : 16'd0;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      daddr_r <= in_data_addr;
      cv_r    <= in_count_or_value;
    end
    if (cmd.cp_use && k_r[0]) hi_r <= rx_q_r;
  end

  // control and sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r      <= 1'b0;
      req_addr_r      <= '0;
      req_func_r      <= '0;
      req_count_low_r <= '0;
      req_start_r     <= '0;
      rx_length_r     <= '0;
      k_r             <= '0;
      crc_r           <= CRC_INIT;
      mism_r          <= 1'b0;
      bad_r           <= 1'b0;
      clr_r           <= '0;
      word_idx_r      <= '0;
    end else begin
      if (cmd.capture) begin
        crc_r  <= CRC_INIT;
        mism_r <= 1'b0;
        bad_r  <= 1'b0;
      end
      if (cmd.req_arm) begin
        awaiting_r      <= 1'b1;
        req_addr_r      <= in_device_addr;
        req_func_r      <= (in_mode == MODE_RD_REQ) ? FUNC_READ : FUNC_WRITE;
        req_count_low_r <= in_count_or_value[7:0] & BYTE_MASK;
        if (in_mode == MODE_RD_REQ) req_start_r <= in_store_start;
        rx_length_r     <= '0;
      end
      if (cmd.rx_push && (rx_length_r < RX_LEN_W'(RX_DEPTH)))
        rx_length_r <= rx_length_r + RX_LEN_W'(1);
      if (cmd.clr_step) clr_r <= clr_r + ST_IDX_W'(1);

      if (cmd.k_clr)         k_r <= '0;
      else if (cmd.cp_start) k_r <= RX_LEN_W'(3);
      else if (cmd.k_inc)    k_r <= k_r + RX_LEN_W'(1);

      if (cmd.crc_req) crc_r <= crc16_byte(crc_r, frame_byte);

      if (cmd.chk_use) begin
        if (k_r == '0 && rx_q_r != req_addr_r)            mism_r <= 1'b1;
        if (k_r == RX_LEN_W'(1) && rx_q_r != req_func_r)  mism_r <= 1'b1;
        if (k_r < lenm2) crc_r <= crc16_byte(crc_r, rx_q_r);
        if (k_r == lenm2 && rx_q_r != crc_r[7:0])         bad_r <= 1'b1;
        if (k_r == lenm1 && rx_q_r != crc_r[15:8])        bad_r <= 1'b1;
      end

      if (cmd.cp_start) word_idx_r <= SA_W'(req_start_r);
      else if (cmd.cp_use && !k_r[0]) word_idx_r <= word_idx_r + SA_W'(1);

      if (cmd.fin) begin
        awaiting_r  <= 1'b0;
        rx_length_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_tx || cmd.fin || cmd.emit_store) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tx) begin
      out_kind_r   <= KIND_TX;
      out_tx_r     <= frame_byte;
      out_last_r   <= (k_r[2:0] == 3'd7);
      out_status_r <= ST_OK;
      out_value_r  <= '0;
    end else if (cmd.fin) begin
      out_kind_r   <= KIND_STATUS;
      out_tx_r     <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= fin_status;
      out_value_r  <= '0;
    end else if (cmd.emit_store) begin
      out_kind_r   <= KIND_STORE;
      out_tx_r     <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= ST_OK;
      out_value_r  <= st_rdata_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_tx_byte   = out_tx_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;
  assign out_reg_value = signed'(out_value_r);

endmodule
`default_nettype wire

// File: rtl/core/modbus_rtu_master_engine_top.sv
// Top level of the Modbus RTU master engine: sequencer plus datapath.
// Depends on mre_pkg, mre_ctrl, mre_dp.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | mode, addresses, count, rx byte, index
//   out_    | output    | out_valid/out_stall | kind, tx_byte, last, status, reg_value
//
// After reset the register store is swept to zero, with the input stalled.
// Request: byte-wide CRC over the six header bytes, then 8 frame bytes one per cycle while the output is free.
// A reply byte is buffered without leaving idle. A store read is registered, then emitted.
// End of reply: if the length fits, a check pass reads each buffered byte (single buffer read
// port, registered); a good read reply then gets a copy pass over its word bytes; then status.
// A stalled output holds its item; the sequencer waits on it before emitting.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_master_engine_top
  import mre_pkg::*;
#(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int DEVICE_COUNT = DEVICE_COUNT_DEF,
  parameter int STATUS_BASE  = STATUS_BASE_DEF,
  parameter int RX_DEPTH     = RX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_mode,
  input  wire logic [7:0]         in_device_addr,
  input  wire logic [15:0]        in_data_addr,
  input  wire logic [15:0]        in_count_or_value,
  input  wire logic [7:0]         in_store_start,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic [7:0]         in_store_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_tx_byte,
  output logic                    out_last,
  output logic [2:0]              out_status,
  output logic signed [15:0]      out_reg_value
);

  cmd_t cmd;
  sts_t sts;

  mre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mre_dp #(
    .STORE_DEPTH  (STORE_DEPTH),
    .DEVICE_COUNT (DEVICE_COUNT),
    .STATUS_BASE  (STATUS_BASE),
    .RX_DEPTH     (RX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_device_addr    (in_device_addr),
    .in_data_addr      (in_data_addr),
    .in_count_or_value (in_count_or_value),
    .in_store_start    (in_store_start),
    .in_rx_byte        (in_rx_byte),
    .in_store_index    (in_store_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_reg_value     (out_reg_value)
  );

endmodule
`default_nettype wire
